FILE: rtl/core/wsts_pkg.sv
// shared constants, codes and request/response types of the sum-tree sampler
package wsts_pkg;

    // tree geometry
    localparam int LEAVES    = 1024;
    localparam int LEAF_W    = $clog2(LEAVES);
    localparam int NODE_W    = LEAF_W + 1;
    localparam int NODES     = 2 * LEAVES;
    localparam int CNT_W     = LEAF_W + 1;
    localparam int RATE_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PICK   = 2'd2;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_WRAP  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // engine sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UP,
        S_DOWN,
        S_HOLD
    } t_state;

    // one decoded request handed to the engine
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [LEAF_W-1:0] leaf;
        logic [RATE_W-1:0] delta;
        logic              positive;
        logic [RATE_W-1:0] random;
    } t_req;

    // one finished response from the engine
    typedef struct packed {
        logic [LEAF_W-1:0] chosen;
        logic [RATE_W-1:0] total;
        t_status           status;
    } t_resp;

endpackage

FILE: rtl/core/wsts_tree_engine.sv
// node memory and the sequencer that walks the sum tree up and down
module wsts_tree_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  wsts_pkg::t_req i_req,
    input  logic           i_resp_take,
    output logic           o_idle,
    output logic           o_done,
    output wsts_pkg::t_resp o_resp
);

    localparam logic [wsts_pkg::NODE_W-1:0] LEAF_BASE = wsts_pkg::NODE_W'(wsts_pkg::LEAVES);
    localparam logic [wsts_pkg::NODE_W-1:0] ROOT      = wsts_pkg::NODE_W'(1);
    localparam logic [wsts_pkg::NODE_W-1:0] ROOT_LEFT = wsts_pkg::NODE_W'(2);
    localparam logic [wsts_pkg::NODE_W-1:0] LAST_NODE = wsts_pkg::NODE_W'(wsts_pkg::NODES - 1);

    // node sums, node 1 is the root, leaf i at node LEAVES+i
    logic [wsts_pkg::RATE_W-1:0] mem [wsts_pkg::NODES];

    wsts_pkg::t_state             r_state, n_state;
    logic [wsts_pkg::NODE_W-1:0]  r_clr, n_clr;
    logic [wsts_pkg::CNT_W-1:0]   r_count, n_count;
    logic [wsts_pkg::RATE_W-1:0]  r_total, n_total;
    logic [wsts_pkg::NODE_W-1:0]  r_node, n_node;
    logic [wsts_pkg::RATE_W-1:0]  r_delta, n_delta;
    logic                         r_pos, n_pos;
    logic [wsts_pkg::RATE_W-1:0]  r_rand, n_rand;
    logic                         r_wrap, n_wrap;
    logic [wsts_pkg::LEAF_W-1:0]  r_chosen, n_chosen;
    wsts_pkg::t_status            r_status, n_status;
    logic [wsts_pkg::RATE_W-1:0]  r_rd_data;

    logic                         mem_we;
    logic [wsts_pkg::NODE_W-1:0]  mem_waddr;
    logic [wsts_pkg::RATE_W-1:0]  mem_wdata;
    logic [wsts_pkg::NODE_W-1:0]  mem_raddr;

    logic                         is_full;
    logic                         leaf_known;
    logic                         above_total;
    logic [wsts_pkg::RATE_W-1:0]  up_sum;
    logic                         up_wrap;
    logic                         go_right;
    logic                         at_bottom;
    logic [wsts_pkg::NODE_W-1:0]  dn_next;

    // request checks against the current tree
    assign is_full     = r_count >= wsts_pkg::CNT_W'(wsts_pkg::LEAVES);
    assign leaf_known  = {1'b0, i_req.leaf} < r_count;
    assign above_total = i_req.random > r_total;

    // upward step: add delta to the node just read
    assign up_sum  = r_rd_data + r_delta;
    assign up_wrap = r_pos && (up_sum < r_delta);

    // downward step: read data is the left child of r_node
    assign go_right  = r_rand > r_rd_data;
    assign at_bottom = r_node[wsts_pkg::NODE_W-2];
    assign dn_next   = {r_node[wsts_pkg::NODE_W-2:0], go_right};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wsts_pkg::S_CLEAR: begin
                if (r_clr == LAST_NODE) n_state = wsts_pkg::S_IDLE;
            end
            wsts_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_req.cmd)
                        wsts_pkg::CMD_APPEND: begin
                            n_state = is_full ? wsts_pkg::S_HOLD : wsts_pkg::S_UP;
                        end
                        wsts_pkg::CMD_UPDATE: begin
                            n_state = leaf_known ? wsts_pkg::S_UP : wsts_pkg::S_HOLD;
                        end
                        wsts_pkg::CMD_PICK: begin
                            n_state = above_total ? wsts_pkg::S_HOLD : wsts_pkg::S_DOWN;
                        end
                        default: n_state = wsts_pkg::S_HOLD;
                    endcase
                end
            end
            wsts_pkg::S_UP: begin
                if (r_node == ROOT) n_state = wsts_pkg::S_HOLD;
            end
            wsts_pkg::S_DOWN: begin
                if (at_bottom) n_state = wsts_pkg::S_HOLD;
            end
            wsts_pkg::S_HOLD: begin
                if (i_resp_take) n_state = wsts_pkg::S_IDLE;
            end
            default: n_state = wsts_pkg::S_CLEAR;
        endcase
    end

    // datapath and memory port control
    always_comb begin
        n_clr     = r_clr;
        n_count   = r_count;
        n_total   = r_total;
        n_node    = r_node;
        n_delta   = r_delta;
        n_pos     = r_pos;
        n_rand    = r_rand;
        n_wrap    = r_wrap;
        n_chosen  = r_chosen;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_node;
        mem_wdata = up_sum;
        mem_raddr = r_node;
        unique case (r_state)
            wsts_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + wsts_pkg::NODE_W'(1);
            end
            wsts_pkg::S_IDLE: begin
                if (i_start) begin
                    n_delta  = i_req.delta;
                    n_pos    = i_req.positive;
                    n_rand   = i_req.random;
                    n_wrap   = 1'b0;
                    n_chosen = '0;
                    n_status = wsts_pkg::ST_OK;
                    case (i_req.cmd)
                        wsts_pkg::CMD_APPEND: begin
                            if (is_full) begin
                                n_status = wsts_pkg::ST_FULL;
                            end else begin
                                n_node    = LEAF_BASE
                                          + {1'b0, r_count[wsts_pkg::LEAF_W-1:0]};
                                mem_raddr = n_node;
                                n_chosen  = r_count[wsts_pkg::LEAF_W-1:0];
                                n_count   = r_count + wsts_pkg::CNT_W'(1);
                            end
                        end
                        wsts_pkg::CMD_UPDATE: begin
                            if (leaf_known) begin
                                n_node    = LEAF_BASE + {1'b0, i_req.leaf};
                                mem_raddr = n_node;
                            end
                        end
                        wsts_pkg::CMD_PICK: begin
                            if (above_total) begin
                                n_status = wsts_pkg::ST_RANGE;
                            end else begin
                                n_node    = ROOT;
                                mem_raddr = ROOT_LEFT;
                            end
                        end
                        default: n_status = wsts_pkg::ST_OK;
                    endcase
                end
            end
            wsts_pkg::S_UP: begin
                // write this node back, fetch its parent
                mem_we    = 1'b1;
                n_wrap    = r_wrap | up_wrap;
                n_node    = r_node >> 1;
                mem_raddr = n_node;
                if (r_node == ROOT) begin
                    n_total  = up_sum;
                    n_status = (r_wrap | up_wrap) ? wsts_pkg::ST_WRAP : wsts_pkg::ST_OK;
                end
            end
            wsts_pkg::S_DOWN: begin
                // step to one child, fetch its left child
                if (go_right) n_rand = r_rand - r_rd_data;
                n_node    = dn_next;
                mem_raddr = {dn_next[wsts_pkg::NODE_W-2:0], 1'b0};
                if (at_bottom) n_chosen = dn_next[wsts_pkg::LEAF_W-1:0];
            end
            wsts_pkg::S_HOLD: begin
                n_node = r_node;
            end
            default: n_node = r_node;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsts_pkg::S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_delta  <= n_delta;
        r_pos    <= n_pos;
        r_rand   <= n_rand;
        r_wrap   <= n_wrap;
        r_chosen <= n_chosen;
        r_status <= n_status;
    end

    // node memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rd_data <= mem[mem_raddr];
    end

    // outputs
    always_comb begin
        o_idle        = (r_state == wsts_pkg::S_IDLE);
        o_done        = (r_state == wsts_pkg::S_HOLD);
        o_resp.chosen = r_chosen;
        o_resp.total  = r_total;
        o_resp.status = r_status;
    end

endmodule

FILE: rtl/core/weighted_sum_tree_sampler_core.sv
// top level of the sum-tree sampler: request handshake, engine and result register
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------------
//  request  | in        | i_in_valid / o_in_stall    | i_command, i_leaf_index,
//           |           |                            | i_rate_value, i_random_value
//  result   | out       | o_out_valid / i_out_stall  | o_chosen_leaf, o_total_rate, o_status
//
// append and update walk the path from leaf to root (11 nodes), one node at a time,
// through the single read and write port of the node memory; pick walks the path
// down from the root, one level at a time.
// rejected requests (tree full, unknown leaf, random above total, unused code) skip the walk.
// after reset a clearing pass writes all 2048 nodes, one per cycle; stall stays high.
// the result register frees the engine: a new request is taken while a result waits.
module weighted_sum_tree_sampler_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [wsts_pkg::CMD_W-1:0]       i_command,
    input  logic [wsts_pkg::LEAF_W-1:0]      i_leaf_index,
    input  logic signed [wsts_pkg::RATE_W-1:0] i_rate_value,
    input  logic [wsts_pkg::RATE_W-1:0]      i_random_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [wsts_pkg::LEAF_W-1:0]      o_chosen_leaf,
    output logic [wsts_pkg::RATE_W-1:0]      o_total_rate,
    output logic [wsts_pkg::STATUS_W-1:0]    o_status
);

    wsts_pkg::t_req               req;
    wsts_pkg::t_resp              eng_resp;
    logic                         eng_idle;
    logic                         eng_done;
    logic                         in_acc;
    logic                         out_free;
    logic                         out_load;

    logic                         r_out_valid, n_out_valid;
    logic [wsts_pkg::LEAF_W-1:0]  r_chosen;
    logic [wsts_pkg::RATE_W-1:0]  r_total;
    logic [wsts_pkg::STATUS_W-1:0] r_status;

    // request handshake
    assign o_in_stall = !eng_idle;
    assign in_acc     = i_in_valid && !o_in_stall;

    // request decode, delta sign taken from the rate field
    always_comb begin
        req.cmd      = i_command;
        req.leaf     = i_leaf_index;
        req.delta    = i_rate_value;
        req.positive = !i_rate_value[wsts_pkg::RATE_W-1] && (i_rate_value != '0);
        req.random   = i_random_value;
    end

    wsts_tree_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc),
        .i_req       (req),
        .i_resp_take (out_load),
        .o_idle      (eng_idle),
        .o_done      (eng_done),
        .o_resp      (eng_resp)
    );

    // result register
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = eng_done && out_free;

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load)      n_out_valid = 1'b1;
        else if (out_free) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_chosen <= eng_resp.chosen;
            r_total  <= eng_resp.total;
            r_status <= eng_resp.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_chosen_leaf = r_chosen;
    assign o_total_rate  = r_total;
    assign o_status      = r_status;

    // a taken request keeps the engine busy for at least the next cycle
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("request port open right after a request");

    // the clearing pass holds off requests after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request taken during clearing pass");

    // rejected full or out-of-range requests never name a leaf
    a_reject_no_leaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == wsts_pkg::ST_FULL || o_status == wsts_pkg::ST_RANGE))
        |-> (o_chosen_leaf == '0))
        else $error("rejected request reports a leaf");

    // a finished result waiting on a full result register is not dropped
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eng_done && !out_free) |=> eng_done)
        else $error("engine result lost while result register full");

endmodule
